// File: rtl/unpm_pkg.sv
// Shared types and constants for the ARGB unpremultiply converter.
`default_nettype none

package unpm_pkg;

  localparam int unsigned ChanW    = 8;
  localparam int unsigned NumChan  = 3;
  localparam int unsigned WorkW    = 2 * ChanW;   // dividend and quotient width
  localparam int unsigned NumSteps = WorkW;       // one quotient bit per cell
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [ChanW-1:0] AlphaOpaque = 8'hff;
  localparam logic             CfgIdxAlphaMode = 1'b0;

  // One item in flight through the divider chain.
  typedef struct packed {
    logic                            mode;
    logic [ChanW-1:0]                alpha;
    logic [NumChan-1:0][ChanW-1:0]   raw;
    logic [NumChan-1:0][WorkW-1:0]   work;
    logic [NumChan-1:0][ChanW-1:0]   rem;
    logic                            row_end;
    logic                            frame_end;
  } unpm_stage_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] alpha;
    logic             row_end;
    logic             frame_end;
  } unpm_result_t;

endpackage

`default_nettype wire

// File: rtl/unpm_if.sv
// Stream interfaces for the pixel input and result output channels.
`default_nettype none

interface unpm_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_word;
  logic        row_end;
  logic        frame_end;

  modport source (output valid, output pixel_word, output row_end, output frame_end,
                  input ready);
  modport sink   (input valid, input pixel_word, input row_end, input frame_end,
                  output ready);
endinterface

interface unpm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] alpha_out;
  logic       row_end_out;
  logic       frame_end_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output alpha_out, output row_end_out, output frame_end_out,
                  input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  input alpha_out, input row_end_out, input frame_end_out,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/unpm_cell.sv
// One restoring-division step for all three color channels, registered.
`default_nettype none

module unpm_cell (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  advance,
  input  wire                  valid_in,
  input  unpm_pkg::unpm_stage_t data_in,
  output logic                 valid_out,
  output unpm_pkg::unpm_stage_t data_out
);
  import unpm_pkg::*;

  logic        valid_r;
  unpm_stage_t data_r;
  unpm_stage_t data_nxt;

  always_comb begin
    logic [ChanW:0] trial;
    logic [ChanW:0] diff;
    logic           ge;
    data_nxt = data_in;
    for (int c = 0; c < NumChan; c++) begin
      // bring down the next dividend bit and try to subtract the divisor
      trial = {data_in.rem[c], data_in.work[c][WorkW-1]};
      diff  = trial - {1'b0, data_in.alpha};
      ge    = (trial >= {1'b0, data_in.alpha});
      data_nxt.rem[c]  = ge ? diff[ChanW-1:0] : trial[ChanW-1:0];
      data_nxt.work[c] = {data_in.work[c][WorkW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      data_r <= data_nxt;
    end
  end

  assign valid_out = valid_r;
  assign data_out  = data_r;

endmodule

`default_nettype wire

// File: rtl/unpm_skid.sv
// Output register with a skid entry that decouples the result channel.
`default_nettype none

module unpm_skid (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push,
  input  unpm_pkg::unpm_result_t push_data,
  output logic                  full,
  unpm_out_if.source            out_ch
);
  import unpm_pkg::*;

  logic         out_v_r, out_v_nxt;
  logic         skid_v_r, skid_v_nxt;
  unpm_result_t out_d_r, out_d_nxt;
  unpm_result_t skid_d_r, skid_d_nxt;
  logic         take;

  assign take = out_v_r & out_ch.ready;

  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    out_d_nxt  = out_d_r;
    skid_d_nxt = skid_d_r;
    if (!out_v_r || take) begin
      if (skid_v_r) begin
        // drain the parked request first
        out_v_nxt  = 1'b1;
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end else begin
        out_v_nxt = push;
        out_d_nxt = push_data;
      end
    end else if (push) begin
      // output stalled: park the arriving request
      skid_v_nxt = 1'b1;
      skid_d_nxt = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign full                 = skid_v_r;
  assign out_ch.valid         = out_v_r;
  assign out_ch.red_out       = out_d_r.red;
  assign out_ch.green_out     = out_d_r.green;
  assign out_ch.blue_out      = out_d_r.blue;
  assign out_ch.alpha_out     = out_d_r.alpha;
  assign out_ch.row_end_out   = out_d_r.row_end;
  assign out_ch.frame_end_out = out_d_r.frame_end;

endmodule

`default_nettype wire

// File: rtl/unpm_cfg.sv
// APB-style register block holding the alpha mode bit.
`default_nettype none

module unpm_cfg (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire  [unpm_pkg::CfgAddrW-1:0]      paddr,
  input  wire  [unpm_pkg::CfgDataW-1:0]      pwdata,
  output logic [unpm_pkg::CfgDataW-1:0]      prdata,
  output logic                               pready,
  output logic                               alpha_mode
);
  import unpm_pkg::*;

  logic alpha_mode_r;
  logic hit;

  assign hit = (paddr[CfgAddrW-1:2] == CfgIdxAlphaMode);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_mode_r <= 1'b1;
    end else if (psel && penable && pwrite && hit) begin
      alpha_mode_r <= pwdata[0];
    end
  end

  assign pready     = 1'b1;
  assign prdata     = hit ? {{(CfgDataW-1){1'b0}}, alpha_mode_r} : '0;
  assign alpha_mode = alpha_mode_r;

endmodule

`default_nettype wire

// File: rtl/argb_unpremultiply_converter.sv
// Top level: premultiplied ARGB32 to straight RGBA8 converter.
//
//   channel   direction  handshake          payload
//   in_ch     sink       valid/ready        pixel_word, row_end, frame_end
//   out_ch    source     valid/ready        red/green/blue/alpha_out, row/frame_end_out
//   apb       slave      psel/penable       paddr, pwdata, prdata, pready (alpha_mode)
//
// One pixel is accepted per cycle while in_ch.ready is high; each passes a
// chain of 16 division cells, one quotient bit per cell, and its result
// shows on out_ch from the skid block's output register.
// Reset empties the chain and sets alpha_mode to 1.
// A stall on out_ch parks one request in the skid entry; the whole chain
// then holds and in_ch.ready drops until the skid entry drains.
`default_nettype none

module argb_unpremultiply_converter (
  input  wire                           clk,
  input  wire                           rst_n,
  unpm_in_if.sink                       in_ch,
  unpm_out_if.source                    out_ch,
  input  wire                           psel,
  input  wire                           penable,
  input  wire                           pwrite,
  input  wire  [unpm_pkg::CfgAddrW-1:0] paddr,
  input  wire  [unpm_pkg::CfgDataW-1:0] pwdata,
  output logic [unpm_pkg::CfgDataW-1:0] prdata,
  output logic                          pready
);
  import unpm_pkg::*;

  logic         alpha_mode;
  logic         skid_full;
  logic         advance;
  logic         chain_v [NumSteps+1];
  unpm_stage_t  chain_d [NumSteps+1];
  unpm_stage_t  head_d;
  unpm_stage_t  last_d;
  unpm_result_t result;
  logic         a_zero;

  unpm_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .alpha_mode (alpha_mode)
  );

  assign advance     = !skid_full;
  assign in_ch.ready = advance;

  // load dividend c*255 + alpha/2 for each channel
  always_comb begin
    logic [ChanW-1:0] ch;
    head_d.mode      = alpha_mode;
    head_d.alpha     = in_ch.pixel_word[31:24];
    head_d.row_end   = in_ch.row_end;
    head_d.frame_end = in_ch.frame_end;
    for (int c = 0; c < NumChan; c++) begin
      ch = in_ch.pixel_word[c*ChanW +: ChanW];
      head_d.raw[c]  = ch;
      head_d.rem[c]  = '0;
      head_d.work[c] = {ch, {ChanW{1'b0}}} - {{ChanW{1'b0}}, ch}
                       + {{(ChanW+1){1'b0}}, in_ch.pixel_word[31:25]};
    end
  end
  assign chain_d[0] = head_d;
  assign chain_v[0] = in_ch.valid;

  for (genvar i = 0; i < NumSteps; i++) begin : g_cell
    unpm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .advance   (advance),
      .valid_in  (chain_v[i]),
      .data_in   (chain_d[i]),
      .valid_out (chain_v[i+1]),
      .data_out  (chain_d[i+1])
    );
  end

  assign last_d = chain_d[NumSteps];
  assign a_zero = (last_d.alpha == '0);

  always_comb begin
    result.row_end   = last_d.row_end;
    result.frame_end = last_d.frame_end;
    if (last_d.mode) begin
      result.alpha = last_d.alpha;
      result.red   = a_zero ? '0 : last_d.work[2][ChanW-1:0];
      result.green = a_zero ? '0 : last_d.work[1][ChanW-1:0];
      result.blue  = a_zero ? '0 : last_d.work[0][ChanW-1:0];
    end else begin
      result.alpha = AlphaOpaque;
      result.red   = last_d.raw[2];
      result.green = last_d.raw[1];
      result.blue  = last_d.raw[0];
    end
  end

  unpm_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (chain_v[NumSteps] & advance),
    .push_data (result),
    .full      (skid_full),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire
